### rtl/core/cwmf_pkg.sv
package cwmf_pkg;

  // Frame geometry
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int DIM_W = 11;
  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
  localparam logic [DIM_W-1:0] W_MAX = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] H_MAX = DIM_W'(MAX_HEIGHT);

  // Pixel and window geometry
  localparam int PIX_W = 8;
  localparam int WIN_SIDE = 5;
  localparam int WIN_N = WIN_SIDE * WIN_SIDE;
  localparam int LB_ROWS = WIN_SIDE - 1;
  localparam int CNT_W = $clog2(WIN_N + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_WINDOW_MODE  = 2'd2
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;
  typedef logic [WIN_N-1:0] mask_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             drain;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic             frame_end;
  } out_item_t;

  // Window handed to the median stage
  typedef struct packed {
    win_t  win;
    mask_t mask;
    logic  last;
  } med_req_t;

endpackage

### rtl/core/cwmf_median.sv
module cwmf_median import cwmf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  med_req_t  req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic                v3_q, v4_q, ov_q;
  logic                rdy3, rdy4, rdy_out;
  win_t                vals3_q;
  mask_t               mask3_q;
  logic                last3_q, last4_q;
  logic [WIN_N-1:0]    lt_d [WIN_N];
  logic [WIN_N-1:0]    lt3_q [WIN_N];
  logic [CNT_W-1:0]    cnt, kmid, kmid_m1, rank;
  pix_t                lo_d, hi_d, lo4_q, hi4_q;
  logic                odd4_q;
  out_item_t           out_q;

  assign rdy_out = !ov_q || out_ready_i;
  assign rdy4    = !v4_q || rdy_out;
  assign rdy3    = !v3_q || rdy4;
  assign ready_o = rdy3;

  // Pairwise order, ties broken by window position
  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      for (int j = 0; j < WIN_N; j++) begin
        lt_d[i][j] = req_i.mask[j] &&
                     ((req_i.win[j] < req_i.win[i]) ||
                      ((req_i.win[j] == req_i.win[i]) && (j < i)));
      end
    end
  end

  // Rank of each element, pick the two middle ones
  always_comb begin
    cnt     = CNT_W'($countones(mask3_q));
    kmid    = cnt >> 1;
    kmid_m1 = kmid - 1'b1;
    lo_d    = '0;
    hi_d    = '0;
    rank    = '0;
    for (int i = 0; i < WIN_N; i++) begin
      rank = CNT_W'($countones(lt3_q[i]));
      if (mask3_q[i] && (rank == kmid)) begin
        hi_d = hi_d | vals3_q[i];
      end
      if (mask3_q[i] && (rank == kmid_m1)) begin
        lo_d = lo_d | vals3_q[i];
      end
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_q <= valid_i;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
      if (rdy_out) begin
        ov_q <= v4_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (rdy3 && valid_i) begin
      vals3_q <= req_i.win;
      mask3_q <= req_i.mask;
      last3_q <= req_i.last;
      for (int i = 0; i < WIN_N; i++) begin
        lt3_q[i] <= lt_d[i];
      end
    end
    if (rdy4 && v3_q) begin
      lo4_q   <= lo_d;
      hi4_q   <= hi_d;
      odd4_q  <= cnt[0];
      last4_q <= last3_q;
    end
    if (rdy_out && v4_q) begin
      out_q.median    <= odd4_q ? hi4_q :
                         PIX_W'(({1'b0, lo4_q} + {1'b0, hi4_q}) >> 1);
      out_q.frame_end <= last4_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  // A clipped window holds at least a 2x2 corner
  a_min_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> ($countones(mask3_q) >= 4))
    else $error("median window holds too few pixels");

  a_mid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (lo4_q <= hi4_q))
    else $error("middle values out of order");

endmodule

### rtl/core/clipped_window_median_filter_unit.sv
// Registers: input, window, comparison, middle-value, output. Throughput: one item per cycle
// unless out_ready_i stalls; the first result of a frame follows rad*(width+1)+1 pixels,
// and rad*(width+1) drain items flush the tail of the frame (rad = 1 for 3x3, 2 for 5x5).
// Reset: positions and pipeline clear at once; width 640, height 480, 3x3 window.
// Line buffers are not cleared: rows outside the current frame are masked from the window.
module clipped_window_median_filter_unit import cwmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [DIM_W-1:0] cfg_data_i
);

  // Configuration
  logic [DIM_W-1:0] cfg_w_q, cfg_h_q, w_eff, h_eff;
  logic             cfg_mode_q, cfg_hit;
  logic [1:0]       rad;
  logic [DIM_W:0]   delay;

  // Positions
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [DIM_W-1:0] in_row_q, in_row_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [DIM_W:0]   lag_q, lag_d;

  logic             accept, pre_done, pix_step, act, emit, last;
  logic             col_wrap, new_done, ocol_wrap;
  logic [DIM_W-1:0] col_inc, row_inc, ocol_inc;
  logic [DIM_W:0]   rr, cc;
  logic [WIN_SIDE-1:0] row_ok, col_ok;
  mask_t            mask_d;

  // Pipeline
  logic             v1_q, v2_q, rdy1, rdy2, mv1, load1, med_ready;
  pix_t             pix1_q;
  logic [COL_W-1:0] col1_q;
  logic             emit1_q, last1_q, emit2_q, last2_q;
  mask_t            mask1_q, mask2_q;
  pix_t             rd_q [LB_ROWS];
  pix_t             lb_mem [LB_ROWS][MAX_WIDTH];
  win_t             win_q;
  med_req_t         req;

  // Effective sizes and output delay
  always_comb begin
    if (cfg_w_q < DIM_MIN) begin
      w_eff = DIM_MIN;
    end else if (cfg_w_q > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = cfg_w_q;
    end
    if (cfg_h_q < DIM_MIN) begin
      h_eff = DIM_MIN;
    end else if (cfg_h_q > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = cfg_h_q;
    end
  end

  assign rad   = cfg_mode_q ? 2'd2 : 2'd1;
  assign delay = cfg_mode_q ? ({w_eff, 1'b0} + (DIM_W+1)'(2)) : ({1'b0, w_eff} + 1'b1);

  assign cfg_hit = cfg_we_i && ((cfg_idx_i == CFG_FRAME_WIDTH) ||
                                (cfg_idx_i == CFG_FRAME_HEIGHT) ||
                                (cfg_idx_i == CFG_WINDOW_MODE));

  // Step decision for the item at the input
  assign accept    = in_valid_i && in_ready_o;
  assign pre_done  = in_row_q >= h_eff;
  assign pix_step  = !pre_done && !in_item_i.drain;
  assign act       = pre_done || !in_item_i.drain;
  assign col_inc   = {1'b0, in_col_q} + 1'b1;
  assign col_wrap  = col_inc == w_eff;
  assign row_inc   = in_row_q + 1'b1;
  assign new_done  = col_wrap && (row_inc >= h_eff);
  assign emit      = act && (pre_done || new_done || (lag_q >= delay));
  assign last      = emit && ({1'b0, out_row_q} == (h_eff - 1'b1)) &&
                     ({1'b0, out_col_q} == (w_eff - 1'b1));
  assign ocol_inc  = {1'b0, out_col_q} + 1'b1;
  assign ocol_wrap = ocol_inc == w_eff;

  // Clip mask of the output pixel's window; row 0 / column 0 is the newest
  assign rr = (DIM_W+1)'(out_row_q) + (DIM_W+1)'(rad);
  assign cc = (DIM_W+1)'(out_col_q) + (DIM_W+1)'(rad);

  always_comb begin
    for (int k = 0; k < WIN_SIDE; k++) begin
      row_ok[k] = (rr >= (DIM_W+1)'(k)) && ((rr - (DIM_W+1)'(k)) < {1'b0, h_eff}) &&
                  ((DIM_W+1)'(k) <= (DIM_W+1)'({rad, 1'b0}));
      col_ok[k] = (cc >= (DIM_W+1)'(k)) && ((cc - (DIM_W+1)'(k)) < {1'b0, w_eff}) &&
                  ((DIM_W+1)'(k) <= (DIM_W+1)'({rad, 1'b0}));
    end
    for (int k = 0; k < WIN_SIDE; k++) begin
      for (int j = 0; j < WIN_SIDE; j++) begin
        mask_d[k*WIN_SIDE + j] = row_ok[k] && col_ok[j];
      end
    end
  end

  // Position update
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    if (cfg_hit) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      lag_d     = '0;
    end else if (accept && act) begin
      if (last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        lag_d     = '0;
      end else begin
        if (col_wrap) begin
          in_col_d = '0;
          in_row_d = row_inc;
        end else begin
          in_col_d = col_inc[COL_W-1:0];
        end
        if (pix_step && !emit) begin
          lag_d = lag_q + 1'b1;
        end
        if (emit) begin
          if (ocol_wrap) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = ocol_inc[COL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q    <= DIM_W'(640);
      cfg_h_q    <= DIM_W'(480);
      cfg_mode_q <= 1'b0;
      in_col_q   <= '0;
      in_row_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      lag_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  cfg_w_q    <= cfg_data_i;
          CFG_FRAME_HEIGHT: cfg_h_q    <= cfg_data_i;
          CFG_WINDOW_MODE:  cfg_mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
    end
  end

  // Handshake chain
  assign rdy2       = !v2_q || !emit2_q || med_ready;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;
  assign load1      = accept && act;
  assign mv1        = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= load1;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (load1) begin
      pix1_q  <= in_item_i.pixel;
      col1_q  <= in_col_q;
      emit1_q <= emit;
      last1_q <= last;
      mask1_q <= mask_d;
    end
  end

  // Line buffers: read at acceptance, cascade-write when the item moves on
  always_ff @(posedge clk_i) begin
    if (load1) begin
      for (int k = 0; k < LB_ROWS; k++) begin
        rd_q[k] <= lb_mem[k][in_col_q];
      end
    end
    if (mv1) begin
      lb_mem[0][col1_q] <= pix1_q;
      for (int k = 1; k < LB_ROWS; k++) begin
        lb_mem[k][col1_q] <= rd_q[k-1];
      end
    end
  end

  // Window shift: new column enters at column 0
  always_ff @(posedge clk_i) begin
    if (mv1) begin
      for (int k = 0; k < WIN_SIDE; k++) begin
        win_q[k*WIN_SIDE] <= (k == 0) ? pix1_q : rd_q[(k == 0) ? 0 : k-1];
        for (int j = 1; j < WIN_SIDE; j++) begin
          win_q[k*WIN_SIDE + j] <= win_q[k*WIN_SIDE + j - 1];
        end
      end
      emit2_q <= emit1_q;
      last2_q <= last1_q;
      mask2_q <= mask1_q;
    end
  end

  assign req.win  = win_q;
  assign req.mask = mask2_q;
  assign req.last = last2_q;

  cwmf_median u_median (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v2_q && emit2_q),
    .ready_o     (med_ready),
    .req_i       (req),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  a_out_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, out_col_q} < w_eff)
    else $error("output column beyond frame width");

  a_in_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, in_col_q} < w_eff)
    else $error("input column beyond frame width");

  a_lag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lag_q <= delay)
    else $error("input lead exceeds window delay");

endmodule
